FILE: hw/rtl/wsfr_pkg.sv
package wsfr_pkg;

	// parser phase within one frame
	typedef enum logic [2:0] {
		PH_HDR0  = 3'd0,
		PH_HDR1  = 3'd1,
		PH_EXT16 = 3'd2,
		PH_EXT64 = 3'd3,
		PH_MASK  = 3'd4,
		PH_DATA  = 3'd5
	} phase_t;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic [2:0] EXT16_BYTES = 3'd2;
	localparam logic [2:0] EXT64_WRAP  = 3'd0;
	localparam logic [2:0] MASK_BYTES  = 3'd4;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

endpackage

FILE: hw/rtl/websocket_frame_receiver_core.sv
// websocket frame receiver: parses a byte stream into header and payload results
// an accepted byte waits in the input register; any result it gives is registered
// throughput: 1 byte per cycle unless the result side stalls, set by the single
// state update between the input register and the result register
// reset: arst_n clears the parse state to waiting for the first header byte
module websocket_frame_receiver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic        fin,
	output logic [3:0]  opcode,
	output logic        masked,
	output logic [63:0] payload_length,
	output logic [7:0]  data_byte,
	output logic        last
);
	import wsfr_pkg::*;

	// input register
	logic       v_s1;
	logic [7:0] b_s1;

	// parse state
	phase_t      phase_q, phase_d;
	logic        fin_q, fin_d;
	logic [3:0]  op_q, op_d;
	logic        mask_q, mask_d;
	logic [63:0] fl_q, fl_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [31:0] key_q, key_d;
	logic [63:0] rem_q, rem_d;
	logic [1:0]  ki_q, ki_d;

	// result register
	logic        out_v_q;
	logic        kind_q, fin_oq, mask_oq, last_q;
	logic [3:0]  op_oq;
	logic [63:0] len_q;
	logic [7:0]  data_q;

	logic        adv;
	logic        hdr_done;
	logic        len_done;
	logic        data_end;
	logic        res_v;
	logic        res_last;
	logic [7:0]  res_data;
	logic [7:0]  kb;

	assign adv      = v_s1 && (!out_v_q || out_ready);
	assign in_ready = !v_s1 || adv;

	// accept a byte into the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			b_s1 <= rx_byte;
		end
	end

	// mask key byte for the current payload index
	always_comb begin
		case (ki_q)
			2'd0:    kb = key_q[31:24];
			2'd1:    kb = key_q[23:16];
			2'd2:    kb = key_q[15:8];
			default: kb = key_q[7:0];
		endcase
	end

	// field updates and result for the byte in the input stage
	always_comb begin
		fin_d    = fin_q;
		op_d     = op_q;
		mask_d   = mask_q;
		fl_d     = fl_q;
		cnt_d    = cnt_q;
		key_d    = key_q;
		rem_d    = rem_q;
		ki_d     = ki_q;
		len_done = 1'b0;
		hdr_done = 1'b0;
		data_end = 1'b0;
		res_v    = 1'b0;
		res_last = 1'b0;
		res_data = 8'd0;
		case (phase_q)
			PH_HDR1: begin
				mask_d = b_s1[7];
				cnt_d  = 3'd0;
				if (b_s1[6:0] == LEN_EXT16 || b_s1[6:0] == LEN_EXT64) begin
					fl_d = 64'd0;
				end else begin
					fl_d     = {57'd0, b_s1[6:0]};
					len_done = 1'b1;
				end
			end
			PH_EXT16: begin
				fl_d     = {fl_q[55:0], b_s1};
				cnt_d    = cnt_q + 3'd1;
				len_done = (cnt_d == EXT16_BYTES);
			end
			PH_EXT64: begin
				fl_d     = {fl_q[55:0], b_s1};
				cnt_d    = cnt_q + 3'd1;
				len_done = (cnt_d == EXT64_WRAP);
			end
			PH_MASK: begin
				key_d    = {key_q[23:0], b_s1};
				cnt_d    = cnt_q + 3'd1;
				hdr_done = (cnt_d == MASK_BYTES);
			end
			PH_DATA: begin
				res_v    = 1'b1;
				res_data = b_s1 ^ kb;
				res_last = (rem_q == 64'd1);
				ki_d     = ki_q + 2'd1;
				rem_d    = rem_q - 64'd1;
				data_end = (rem_d == 64'd0);
			end
			default: begin
				fin_d  = b_s1[7];
				op_d   = b_s1[3:0];
				mask_d = 1'b0;
				key_d  = 32'd0;
				fl_d   = 64'd0;
				cnt_d  = 3'd0;
				ki_d   = 2'd0;
				rem_d  = 64'd0;
			end
		endcase
		// length known: go on to the mask key or close the header
		if (len_done) begin
			cnt_d = 3'd0;
			if (!mask_d) begin
				hdr_done = 1'b1;
			end
		end
		if (hdr_done) begin
			res_v    = 1'b1;
			res_last = (fl_d == 64'd0);
			rem_d    = fl_d;
			ki_d     = 2'd0;
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HDR1: begin
				if (b_s1[6:0] == LEN_EXT16) begin
					phase_d = PH_EXT16;
				end else if (b_s1[6:0] == LEN_EXT64) begin
					phase_d = PH_EXT64;
				end
			end
			PH_DATA: begin
				if (data_end) begin
					phase_d = PH_HDR0;
				end
			end
			PH_EXT16, PH_EXT64, PH_MASK: begin
			end
			default: begin
				phase_d = PH_HDR1;
			end
		endcase
		if (len_done && mask_d) begin
			phase_d = PH_MASK;
		end
		if (hdr_done) begin
			phase_d = (fl_d == 64'd0) ? PH_HDR0 : PH_DATA;
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			fin_q   <= 1'b0;
			op_q    <= 4'd0;
			mask_q  <= 1'b0;
			fl_q    <= 64'd0;
			cnt_q   <= 3'd0;
			key_q   <= 32'd0;
			rem_q   <= 64'd0;
			ki_q    <= 2'd0;
		end else if (adv) begin
			phase_q <= phase_d;
			fin_q   <= fin_d;
			op_q    <= op_d;
			mask_q  <= mask_d;
			fl_q    <= fl_d;
			cnt_q   <= cnt_d;
			key_q   <= key_d;
			rem_q   <= rem_d;
			ki_q    <= ki_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= res_v;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_v) begin
			kind_q  <= (phase_q == PH_DATA) ? KIND_PAYLOAD : KIND_HEADER;
			fin_oq  <= fin_d;
			op_oq   <= op_d;
			mask_oq <= mask_d;
			len_q   <= fl_d;
			data_q  <= res_data;
			last_q  <= res_last;
		end
	end

	assign out_valid      = out_v_q;
	assign kind           = kind_q;
	assign fin            = fin_oq;
	assign opcode         = op_oq;
	assign masked         = mask_oq;
	assign payload_length = len_q;
	assign data_byte      = data_q;
	assign last           = last_q;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import wsfr_pkg::*;

	// one result item as seen on the output side
	typedef struct packed {
		logic        kind;
		logic        fin;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] length;
		logic [7:0]  data;
		logic        last;
	} ws_result_t;

	// how a frame's payload length is coded in the header
	typedef enum int {LEN_SHORT, LEN_WIDE16, LEN_WIDE64} len_code_t;

	// who idles in the current stretch of the run
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	localparam int HOLD_CYCLES = 300;
	localparam int NO_CAP      = 32'h7fffffff;

	// frame parser mirror and queue of results still owed by the block
	class frame_scoreboard;
		phase_t      ph;
		logic        fin_q;
		logic [3:0]  op_q;
		logic        mask_q;
		logic [63:0] len_q;
		logic [2:0]  cnt;
		logic [31:0] key;
		logic [63:0] left;
		logic [1:0]  kidx;
		ws_result_t  owed[$];
		int          errors;

		function new();
			ph = PH_HDR0;
			fin_q = 1'b0;
			op_q = 4'd0;
			mask_q = 1'b0;
			len_q = 64'd0;
			cnt = 3'd0;
			key = 32'd0;
			left = 64'd0;
			kidx = 2'd0;
			errors = 0;
		endfunction

		function ws_result_t make_result(logic k, logic [7:0] d, logic l);
			ws_result_t r;
			r.kind = k;
			r.fin = fin_q;
			r.opcode = op_q;
			r.masked = mask_q;
			r.length = len_q;
			r.data = d;
			r.last = l;
			return r;
		endfunction

		// header complete: owe a header result, go to payload or next frame
		function void header_done();
			owed.push_back(make_result(KIND_HEADER, 8'd0, len_q == 64'd0));
			left = len_q;
			kidx = 2'd0;
			ph = (len_q == 64'd0) ? PH_HDR0 : PH_DATA;
		endfunction

		function void length_known();
			cnt = 3'd0;
			if (mask_q)
				ph = PH_MASK;
			else
				header_done();
		endfunction

		// advance the parse by one accepted byte
		function void note_byte(logic [7:0] b);
			logic [6:0] len7;
			logic [7:0] key_byte;
			case (ph)
				PH_HDR1: begin
					len7 = b[6:0];
					mask_q = b[7];
					cnt = 3'd0;
					if (len7 == LEN_EXT16) begin
						len_q = 64'd0;
						ph = PH_EXT16;
					end else if (len7 == LEN_EXT64) begin
						len_q = 64'd0;
						ph = PH_EXT64;
					end else begin
						len_q = 64'(len7);
						length_known();
					end
				end
				PH_EXT16: begin
					len_q = {len_q[55:0], b};
					cnt = cnt + 3'd1;
					if (cnt == EXT16_BYTES)
						length_known();
				end
				PH_EXT64: begin
					len_q = {len_q[55:0], b};
					cnt = cnt + 3'd1;
					if (cnt == EXT64_WRAP)
						length_known();
				end
				PH_MASK: begin
					key = {key[23:0], b};
					cnt = cnt + 3'd1;
					if (cnt == MASK_BYTES)
						header_done();
				end
				PH_DATA: begin
					key_byte = key[8 * (3 - kidx) +: 8];
					owed.push_back(make_result(KIND_PAYLOAD, b ^ key_byte, left == 64'd1));
					kidx = kidx + 2'd1;
					left = left - 64'd1;
					if (left == 64'd0)
						ph = PH_HDR0;
				end
				default: begin
					fin_q = b[7];
					op_q = b[3:0];
					mask_q = 1'b0;
					key = 32'd0;
					len_q = 64'd0;
					cnt = 3'd0;
					kidx = 2'd0;
					left = 64'd0;
					ph = PH_HDR1;
				end
			endcase
		endfunction

		// compare one delivered result with the oldest one owed
		function void check_result(ws_result_t got);
			ws_result_t want;
			if (owed.size() == 0) begin
				$error("result with none owed: kind %0d data %h", got.kind, got.data);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.fin !== want.fin) begin
				$error("fin: expected %0d, got %0d", want.fin, got.fin);
				errors++;
			end
			if (got.opcode !== want.opcode) begin
				$error("opcode: expected %h, got %h", want.opcode, got.opcode);
				errors++;
			end
			if (got.masked !== want.masked) begin
				$error("masked: expected %0d, got %0d", want.masked, got.masked);
				errors++;
			end
			if (got.length !== want.length) begin
				$error("payload_length: expected %h, got %h", want.length, got.length);
				errors++;
			end
			if (got.data !== want.data) begin
				$error("data_byte: expected %h, got %h", want.data, got.data);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic        fin;
	logic [3:0]  opcode;
	logic        masked;
	logic [63:0] payload_length;
	logic [7:0]  data_byte;
	logic        last;

	frame_scoreboard board;
	idle_mode_t      idle_mode = IDLE_NONE;
	int              bytes_sent = 0;
	int              hold_requests = 0;
	int              hold_seen = 0;
	int              hold_left = 0;

	websocket_frame_receiver_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.fin(fin),
		.opcode(opcode),
		.masked(masked),
		.payload_length(payload_length),
		.data_byte(data_byte),
		.last(last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function int sender_idle_pct();
		case (idle_mode)
			IDLE_SENDER: return 85;
			IDLE_BOTH:   return 9;
			default:     return 0;
		endcase
	endfunction

	function int receiver_stall_pct();
		case (idle_mode)
			IDLE_RECEIVER: return 85;
			IDLE_BOTH:     return 9;
			default:       return 0;
		endcase
	endfunction

	// result side: check accepted results, then pick next cycle's ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result({kind, fin, opcode, masked, payload_length, data_byte, last});
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_stall_pct());
		end
	end

	// offer one byte, with a random gap first, and wait for its request to go through
	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < sender_idle_pct()) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct());
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_byte(b);
		bytes_sent++;
	endtask

	// whole frame: header, optional key, random payload (at most cap bytes of it)
	task automatic send_frame(input logic f, input logic [2:0] rsv, input logic [3:0] op,
			input logic m, input logic [63:0] len, input len_code_t code, input int cap);
		logic [31:0]     k;
		longint unsigned i;
		k = $urandom;
		send_byte({f, rsv, op});
		case (code)
			LEN_WIDE16: send_byte({m, LEN_EXT16});
			LEN_WIDE64: send_byte({m, LEN_EXT64});
			default:    send_byte({m, len[6:0]});
		endcase
		if (code == LEN_WIDE16) begin
			send_byte(len[15:8]);
			send_byte(len[7:0]);
		end
		if (code == LEN_WIDE64) begin
			for (i = 0; i < 8; i++)
				send_byte(len[63 - 8 * i -: 8]);
		end
		if (m) begin
			for (i = 0; i < 4; i++)
				send_byte(k[31 - 8 * i -: 8]);
		end
		for (i = 0; i < len && i < cap; i++)
			send_byte(8'($urandom_range(255)));
	endtask

	// sender pause until every owed result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	// stimulus
	initial begin
		int          target;
		int          r;
		int          w;
		len_code_t   code;
		logic [63:0] len;
		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames: empty, reserved bits with masked non-minimal 16-bit length,
		// unmasked 64-bit length, masked empty frame
		send_frame(1'b1, 3'b000, 4'h1, 1'b0, 64'd0, LEN_SHORT, NO_CAP);
		send_frame(1'b0, 3'b111, 4'hA, 1'b1, 64'd1, LEN_WIDE16, NO_CAP);
		send_frame(1'b0, 3'b000, 4'h0, 1'b0, 64'd2, LEN_WIDE64, NO_CAP);
		send_frame(1'b1, 3'b000, 4'hF, 1'b1, 64'd0, LEN_SHORT, NO_CAP);
		drain();

		// random frames, one stretch per idling pattern
		for (int m = 0; m < 4; m++) begin
			idle_mode = idle_mode_t'(m);
			if (idle_mode == IDLE_NONE)
				hold_requests++;
			target = bytes_sent + 410;
			while (bytes_sent < target) begin
				r = $urandom_range(99);
				if (r < 70) begin
					code = LEN_SHORT;
					len = ($urandom_range(19) == 0) ? 64'($urandom_range(125))
						: 64'($urandom_range(12));
				end else if (r < 85) begin
					code = LEN_WIDE16;
					len = ($urandom_range(4) == 0) ? 64'($urandom_range(300, 126))
						: 64'($urandom_range(20));
				end else begin
					code = LEN_WIDE64;
					len = 64'($urandom_range(16));
				end
				send_frame(1'($urandom_range(1)), 3'($urandom_range(7)),
					4'($urandom_range(15)), 1'($urandom_range(1)), len, code, NO_CAP);
			end
			drain();
		end

		// huge 64-bit length with its top bit set; the stream ends inside its payload
		len = {1'b1, 31'($urandom), 32'($urandom)};
		send_frame(1'($urandom_range(1)), 3'($urandom_range(7)), 4'($urandom_range(15)),
			1'b1, len, LEN_WIDE64, 6);
		in_valid <= 1'b0;

		// wait for the tail, then watch on for anything stray
		for (w = 0; w < 20000 && board.pending() != 0; w++)
			@(posedge clk);
		if (board.pending() != 0) begin
			$error("%0d results never arrived", board.pending());
			board.errors++;
		end
		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// overall time limit
	initial begin
		#(12 * 300000);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: websocket_frame_receiver_core.f
hw/rtl/wsfr_pkg.sv
hw/rtl/websocket_frame_receiver_core.sv
tb/sv/testbench.sv
